>>> hdl/cpf_pkg.sv
// Shared constants, types and helpers of the command packet framer.
package cpf_pkg;

    localparam int MAX_PARAMS   = 5;
    localparam int PARAM_FIELDS = 5;
    localparam int PARAM_LIMIT  = (MAX_PARAMS < PARAM_FIELDS) ? MAX_PARAMS : PARAM_FIELDS;

    localparam int COUNT_W = 3;
    localparam int PIDX_W  = (PARAM_FIELDS > 1) ? $clog2(PARAM_FIELDS) : 1;
    localparam int ADDR_W  = 32;
    localparam int SUM_W   = 16;
    localparam int LEN_W   = 16;

    localparam logic [7:0]        HEADER_HI  = 8'hEF;
    localparam logic [7:0]        HEADER_LO  = 8'h01;
    localparam logic [7:0]        CMD_FLAG   = 8'h01;
    localparam logic [ADDR_W-1:0] ADDR_RESET = 32'hFFFF_FFFF;
    localparam int                LEN_BASE   = 3;

    // Byte positions of the fixed part of a packet
    localparam int POS_W = 5;
    localparam logic [POS_W-1:0] POS_HDR_HI = 5'd0;
    localparam logic [POS_W-1:0] POS_HDR_LO = 5'd1;
    localparam logic [POS_W-1:0] POS_ADDR3  = 5'd2;
    localparam logic [POS_W-1:0] POS_ADDR2  = 5'd3;
    localparam logic [POS_W-1:0] POS_ADDR1  = 5'd4;
    localparam logic [POS_W-1:0] POS_ADDR0  = 5'd5;
    localparam logic [POS_W-1:0] POS_FLAG   = 5'd6;
    localparam logic [POS_W-1:0] POS_LEN_HI = 5'd7;
    localparam logic [POS_W-1:0] POS_LEN_LO = 5'd8;
    localparam logic [POS_W-1:0] POS_OPCODE = 5'd9;
    localparam int               FIXED_BYTES = 10;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [PARAM_FIELDS-1:0][7:0] param_vec_t;

    // Classified command waiting for serialization
    typedef struct packed {
        logic [7:0]         opcode;
        logic [COUNT_W-1:0] count;
        logic [LEN_W-1:0]   length;
        param_vec_t         params;
        logic [SUM_W-1:0]   checksum;
    } cpf_cmd_t;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              full;
        logic              empty;
    } cpf_qstat_t;

endpackage

>>> hdl/cpf_channels.sv
// Channel interfaces of the command packet framer: request, byte stream, configuration.
interface cpf_req_if;
    logic                        valid;
    logic                        ready;
    logic [7:0]                  opcode;
    logic [cpf_pkg::COUNT_W-1:0] param_count;
    logic [7:0]                  param_byte_0;
    logic [7:0]                  param_byte_1;
    logic [7:0]                  param_byte_2;
    logic [7:0]                  param_byte_3;
    logic [7:0]                  param_byte_4;

    modport source (
        output valid, opcode, param_count,
        output param_byte_0, param_byte_1, param_byte_2, param_byte_3, param_byte_4,
        input  ready
    );
    modport sink (
        input  valid, opcode, param_count,
        input  param_byte_0, param_byte_1, param_byte_2, param_byte_3, param_byte_4,
        output ready
    );
endinterface

interface cpf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_byte;
    logic       last_byte;

    modport source (output valid, tx_byte, last_byte, input ready);
    modport sink   (input valid, tx_byte, last_byte, output ready);
endinterface

interface cpf_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [cpf_pkg::ADDR_W-1:0] module_address;

    modport source (output valid, module_address, input ready);
    modport sink   (input valid, module_address, output ready);
endinterface

>>> hdl/command_packet_framer_top.sv
// Top level of the command packet framer: address register, front end, queue, back end.
//
// Channels: req takes one command (opcode, param_count, five parameter bytes) per
// valid/ready handshake; tx sends the serial packet one byte per handshake, with
// last_byte set on the low checksum byte; cfg writes the 32-bit module address.
// A param_count above five is treated as five.
// Packet: EF 01, address (MSB first), 01, length (count + 3), opcode, parameters,
// checksum (sum of flag, length bytes, opcode and parameters, modulo 65536).
// The first byte of an item is registered in the output register once the item has
// passed the command queue. The back-end byte sequencer sends one byte per cycle
// while tx is ready; items are 12 + param_count bytes (12 to 17), back to back.
// A two-entry command queue lets req take up to two items ahead of the packet on air.
// A stall on tx holds the current byte in the output register and freezes the
// sequencer; req ready drops only when the queue is full.
// Reset clears the queue, the sequencer and the output valid, and sets the module
// address to FFFFFFFF. Write cfg only while no packet is pending; it is always ready.
module command_packet_framer_top (
    input  logic       clk,
    input  logic       rst_n,
    cpf_req_if.sink    req,
    cpf_byte_if.source tx,
    cpf_cfg_if.sink    cfg
);
    import cpf_pkg::*;

    logic [ADDR_W-1:0] addr_reg;
    logic              push;
    logic              pop;
    cpf_cmd_t          push_cmd;
    cpf_cmd_t          head;
    cpf_qstat_t        q_stat;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg <= ADDR_RESET;
        end
        else if (cfg.valid)
        begin
            addr_reg <= cfg.module_address;
        end
    end

    cpf_front u_front (
        .req      (req),
        .q_full   (q_stat.full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    cpf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .stat     (q_stat)
    );

    cpf_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .module_address (addr_reg),
        .head           (head),
        .head_valid     (!q_stat.empty),
        .pop            (pop),
        .tx             (tx)
    );

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.count <= QCNT_W'(QUEUE_DEPTH))
        else $error("command queue count above depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("pop from empty command queue");

    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !q_stat.empty)
        else $error("accepted item missing from command queue");

endmodule

>>> hdl/cpf_front.sv
// Front end: accepts requests, saturates the count, computes length and checksum.
module cpf_front (
    cpf_req_if.sink             req,
    input  logic                q_full,
    output logic                push,
    output cpf_pkg::cpf_cmd_t   push_cmd
);
    import cpf_pkg::*;

    logic [COUNT_W-1:0] cnt;
    logic [LEN_W-1:0]   len;
    param_vec_t         params;
    logic [SUM_W-1:0]   sum;

    assign req.ready = !q_full;
    assign push      = req.valid && !q_full;

    assign params[0] = req.param_byte_0;
    assign params[1] = req.param_byte_1;
    assign params[2] = req.param_byte_2;
    assign params[3] = req.param_byte_3;
    assign params[4] = req.param_byte_4;

    always_comb
    begin
        if (req.param_count > COUNT_W'(PARAM_LIMIT))
        begin
            cnt = COUNT_W'(PARAM_LIMIT);
        end
        else
        begin
            cnt = req.param_count;
        end
        len = LEN_W'(cnt) + LEN_W'(LEN_BASE);
        sum = SUM_W'(CMD_FLAG) + SUM_W'(len[15:8]) + SUM_W'(len[7:0]) + SUM_W'(req.opcode);
        // drop parameter bytes beyond the count
        for (int i = 0; i < PARAM_FIELDS; i++)
        begin
            if (COUNT_W'(i) < cnt)
            begin
                sum = sum + SUM_W'(params[i]);
            end
        end
    end

    assign push_cmd.opcode   = req.opcode;
    assign push_cmd.count    = cnt;
    assign push_cmd.length   = len;
    assign push_cmd.params   = params;
    assign push_cmd.checksum = sum;

endmodule

>>> hdl/cpf_queue.sv
// Short command queue between front and back end, head visible without a pop.
module cpf_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  cpf_pkg::cpf_cmd_t   push_cmd,
    input  logic                pop,
    output cpf_pkg::cpf_cmd_t   head,
    output cpf_pkg::cpf_qstat_t stat
);
    import cpf_pkg::*;

    cpf_cmd_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        logic [QPTR_W-1:0] r;
        if (p == QPTR_W'(QUEUE_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    assign stat.count = count_reg;
    assign stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign head       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> hdl/cpf_back.sv
// Back end: serializes one queued command into packet bytes through an output register.
module cpf_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [cpf_pkg::ADDR_W-1:0] module_address,
    input  cpf_pkg::cpf_cmd_t         head,
    input  logic                      head_valid,
    output logic                      pop,
    cpf_byte_if.source                tx
);
    import cpf_pkg::*;

    cpf_cmd_t         desc_reg;
    logic             active_reg;
    logic             active_next;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [7:0]       out_byte_reg;
    logic             out_last_reg;

    cpf_cmd_t         cur;
    logic             have;
    logic             load;
    logic             step;
    logic             is_last;
    logic [POS_W-1:0] last_pos;
    logic [POS_W-1:0] k;
    logic [7:0]       byte_sel;

    // Start the next packet straight from the queue head, no gap cycle
    assign cur      = active_reg ? desc_reg : head;
    assign have     = active_reg || head_valid;
    assign load     = !out_valid_reg || tx.ready;
    assign step     = load && have;
    assign pop      = step && !active_reg;
    assign last_pos = POS_W'(FIXED_BYTES + 1) + POS_W'(cur.count);
    assign is_last  = (pos_reg == last_pos);
    assign k        = pos_reg - POS_W'(FIXED_BYTES);

    always_comb
    begin
        unique case (pos_reg)
            POS_HDR_HI: byte_sel = HEADER_HI;
            POS_HDR_LO: byte_sel = HEADER_LO;
            POS_ADDR3:  byte_sel = module_address[31:24];
            POS_ADDR2:  byte_sel = module_address[23:16];
            POS_ADDR1:  byte_sel = module_address[15:8];
            POS_ADDR0:  byte_sel = module_address[7:0];
            POS_FLAG:   byte_sel = CMD_FLAG;
            POS_LEN_HI: byte_sel = cur.length[15:8];
            POS_LEN_LO: byte_sel = cur.length[7:0];
            POS_OPCODE: byte_sel = cur.opcode;
            default:
            begin
                priority if (k < POS_W'(cur.count))
                begin
                    byte_sel = cur.params[k[PIDX_W-1:0]];
                end
                else if (k == POS_W'(cur.count))
                begin
                    byte_sel = cur.checksum[15:8];
                end
                else
                begin
                    byte_sel = cur.checksum[7:0];
                end
            end
        endcase
    end

    always_comb
    begin
        active_next    = active_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        if (step)
        begin
            out_valid_next = 1'b1;
            if (is_last)
            begin
                active_next = 1'b0;
                pos_next    = '0;
            end
            else
            begin
                active_next = 1'b1;
                pos_next    = pos_reg + 1'b1;
            end
        end
        else if (load)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            desc_reg <= head;
        end
        if (step)
        begin
            out_byte_reg <= byte_sel;
            out_last_reg <= is_last;
        end
    end

    assign tx.valid     = out_valid_reg;
    assign tx.tx_byte   = out_byte_reg;
    assign tx.last_byte = out_last_reg;

endmodule

>>> dv/tb.sv
// Testbench for the command packet framer: directed table, random commands, byte-level check.
module tb;
    import cpf_pkg::*;

    localparam int ITEM_LIMIT   = 1000000;
    localparam int PHASE_ITEMS  = 80;
    localparam int DRAIN_CYCLES = 4;

    typedef struct packed {
        logic [7:0]         opcode;
        logic [COUNT_W-1:0] count;
        param_vec_t         params;
    } command_t;

    // Row of the directed table; a typed row carries its checksum read off by hand
    typedef struct packed {
        command_t   cmd;
        logic       typed;
        logic [15:0] checksum;
    } command_row_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last_byte;
    } wire_byte_t;

    logic clk;
    logic rst_n;

    cpf_req_if  req_ch ();
    cpf_byte_if tx_ch ();
    cpf_cfg_if  cfg_ch ();

    command_packet_framer_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .tx    (tx_ch),
        .cfg   (cfg_ch)
    );

    wire_byte_t   wire_bytes_q[$];
    wire_byte_t   wire_head;
    logic [31:0]  device_address;
    int           mismatch_count;
    int           cycle_count;
    int           burst_left;
    int           stall_mode;
    int           stall_left;
    int           stall_tick;
    command_row_t directed_rows[$];
    logic [31:0]  phase_address[$];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic command_row_t mk_row(input logic [7:0] opcode,
                                            input logic [COUNT_W-1:0] count,
                                            input logic [39:0] params,
                                            input logic typed,
                                            input logic [15:0] checksum);
        command_row_t row;
        row.cmd.opcode = opcode;
        row.cmd.count  = count;
        row.cmd.params = params;
        row.typed      = typed;
        row.checksum   = checksum;
        return row;
    endfunction

    // Build the wire bytes of one command against the current module address
    function automatic void frame_command(input command_t cmd, input logic typed,
                                          input logic [15:0] typed_sum);
        int          n;
        logic [15:0] length;
        logic [15:0] checksum;
        n = (cmd.count > PARAM_LIMIT) ? PARAM_LIMIT : int'(cmd.count);
        length = 16'(n + LEN_BASE);
        checksum = 16'(CMD_FLAG) + 16'(length[15:8]) + 16'(length[7:0]) + 16'(cmd.opcode);
        for (int i = 0; i < n; i++)
            checksum = checksum + 16'(cmd.params[i]);
        if (typed)
            checksum = typed_sum;
        wire_bytes_q.push_back({HEADER_HI, 1'b0});
        wire_bytes_q.push_back({HEADER_LO, 1'b0});
        wire_bytes_q.push_back({device_address[31:24], 1'b0});
        wire_bytes_q.push_back({device_address[23:16], 1'b0});
        wire_bytes_q.push_back({device_address[15:8], 1'b0});
        wire_bytes_q.push_back({device_address[7:0], 1'b0});
        wire_bytes_q.push_back({CMD_FLAG, 1'b0});
        wire_bytes_q.push_back({length[15:8], 1'b0});
        wire_bytes_q.push_back({length[7:0], 1'b0});
        wire_bytes_q.push_back({cmd.opcode, 1'b0});
        for (int i = 0; i < n; i++)
            wire_bytes_q.push_back({cmd.params[i], 1'b0});
        wire_bytes_q.push_back({checksum[15:8], 1'b0});
        wire_bytes_q.push_back({checksum[7:0], 1'b1});
    endfunction

    // Favor the all-zero and all-one bytes now and then
    function automatic logic [7:0] random_byte();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0)
            return 8'h00;
        if (pick == 1)
            return 8'hFF;
        return 8'($urandom);
    endfunction

    function automatic command_t random_command();
        command_t cmd;
        cmd.opcode = random_byte();
        if ($urandom_range(0, 9) == 0)
            cmd.count = COUNT_W'($urandom_range(6, 7));
        else
            cmd.count = COUNT_W'($urandom_range(0, 5));
        for (int i = 0; i < PARAM_FIELDS; i++)
            cmd.params[i] = random_byte();
        return cmd;
    endfunction

    // Call at a falling edge; returns at the falling edge after acceptance
    task automatic send_command(input command_t cmd, input logic typed,
                                input logic [15:0] typed_sum);
        int gap;
        if (burst_left == 0)
        begin
            req_ch.valid <= 1'b0;
            gap = $urandom_range(1, 8);
            repeat (gap) @(negedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 10);
        end
        req_ch.valid        <= 1'b1;
        req_ch.opcode       <= cmd.opcode;
        req_ch.param_count  <= cmd.count;
        req_ch.param_byte_0 <= cmd.params[0];
        req_ch.param_byte_1 <= cmd.params[1];
        req_ch.param_byte_2 <= cmd.params[2];
        req_ch.param_byte_3 <= cmd.params[3];
        req_ch.param_byte_4 <= cmd.params[4];
        do
            @(posedge clk);
        while (!req_ch.ready);
        frame_command(cmd, typed, typed_sum);
        burst_left--;
        @(negedge clk);
    endtask

    task automatic write_address(input logic [31:0] address);
        cfg_ch.module_address <= address;
        cfg_ch.valid          <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        device_address = address;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    // Hold until every expected byte is out, then let the sequencer settle
    task automatic drain();
        req_ch.valid <= 1'b0;
        while (wire_bytes_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Receiver: switch between stall patterns every so often
    always @(negedge clk)
    begin
        stall_tick <= stall_tick + 1;
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 200);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_mode)
            0: tx_ch.ready <= 1'b1;
            1: tx_ch.ready <= ($urandom_range(0, 3) != 0);
            2: tx_ch.ready <= ((stall_tick % 5) != 3);
            default: tx_ch.ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && tx_ch.valid && tx_ch.ready)
        begin
            if (wire_bytes_q.size() == 0)
            begin
                $error("tx_byte: no item expected, got 0x%02h", tx_ch.tx_byte);
                mismatch_count++;
            end
            else
            begin
                wire_head = wire_bytes_q.pop_front();
                if (tx_ch.tx_byte !== wire_head.tx_byte)
                begin
                    $error("tx_byte: expected 0x%02h, got 0x%02h",
                           wire_head.tx_byte, tx_ch.tx_byte);
                    mismatch_count++;
                end
                if (tx_ch.last_byte !== wire_head.last_byte)
                begin
                    $error("last_byte: expected %0b, got %0b",
                           wire_head.last_byte, tx_ch.last_byte);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= ITEM_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        rst_n                 = 1'b0;
        req_ch.valid          = 1'b0;
        req_ch.opcode         = '0;
        req_ch.param_count    = '0;
        req_ch.param_byte_0   = '0;
        req_ch.param_byte_1   = '0;
        req_ch.param_byte_2   = '0;
        req_ch.param_byte_3   = '0;
        req_ch.param_byte_4   = '0;
        tx_ch.ready           = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.module_address = '0;
        device_address        = ADDR_RESET;
        mismatch_count        = 0;
        cycle_count           = 0;
        burst_left            = 0;
        stall_mode            = 0;
        stall_left            = 0;
        stall_tick            = 0;

        directed_rows = '{
            mk_row(8'h00, 3'd0, 40'h00_00_00_00_00, 1'b1, 16'h0004),
            mk_row(8'hFF, 3'd0, 40'h00_00_00_00_00, 1'b1, 16'h0103),
            mk_row(8'h00, 3'd5, 40'h00_00_00_00_00, 1'b1, 16'h0009),
            mk_row(8'hFF, 3'd5, 40'hFF_FF_FF_FF_FF, 1'b1, 16'h0603),
            mk_row(8'h00, 3'd7, 40'hFF_FF_FF_FF_FF, 1'b1, 16'h0504),
            mk_row(8'h10, 3'd6, 40'h05_04_03_02_01, 1'b1, 16'h0028),
            mk_row(8'hA5, 3'd1, 40'hFF_FF_FF_FF_5A, 1'b0, 16'h0000),
            mk_row(8'h5A, 3'd2, 40'hFF_FF_FF_A5_C3, 1'b0, 16'h0000),
            mk_row(8'h3C, 3'd3, 40'hFF_FF_80_7F_01, 1'b0, 16'h0000),
            mk_row(8'hC3, 3'd4, 40'hEE_81_7E_00_FF, 1'b0, 16'h0000),
            mk_row(8'h01, 3'd5, 40'h55_AA_55_AA_55, 1'b0, 16'h0000),
            mk_row(8'h80, 3'd5, 40'hAA_55_AA_55_AA, 1'b0, 16'h0000),
            mk_row(8'h7F, 3'd0, 40'h12_34_56_78_9A, 1'b0, 16'h0000),
            mk_row(8'h00, 3'd2, 40'hFF_FF_FF_00_00, 1'b0, 16'h0000),
            mk_row(8'hFF, 3'd4, 40'h00_FF_FF_FF_FF, 1'b0, 16'h0000),
            mk_row(8'h6E, 3'd6, 40'h9C_3B_E4_17_D2, 1'b0, 16'h0000)
        };
        phase_address = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hA5C3_0F96,
                          $urandom, $urandom};

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed rows run at the reset address
        foreach (directed_rows[i])
            send_command(directed_rows[i].cmd, directed_rows[i].typed,
                         directed_rows[i].checksum);
        drain();

        foreach (phase_address[p])
        begin
            write_address(phase_address[p]);
            repeat (PHASE_ITEMS) send_command(random_command(), 1'b0, 16'h0000);
            drain();
        end

        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
